[rtl/srb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

  localparam int DEFAULT_RING_DEPTH = 256;

  localparam int SEQ_W  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 8;
  localparam int HELD_W = 9;
  localparam int FLAG_W = 3;

  // Bit positions inside the stored flag field.
  localparam int FLAG_HW  = 0;
  localparam int FLAG_GAP = 1;
  localparam int FLAG_OVW = 2;

  // One ring entry is the flags on top of the payload word.
  localparam int ENTRY_W = FLAG_W + WORD_W;

  typedef enum logic [1:0] {
    KIND_ARRIVAL  = 2'd0,
    KIND_READ     = 2'd1,
    KIND_OVERSIZE = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

`default_nettype wire

[rtl/sequenced_packet_ring_buffer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Carries
// in_       input      in_valid / in_stall   kind, sequence number, flag, length ok, word
// out_      output     out_valid / out_stall one result word per input word
// cfg_      input      cfg_valid / cfg_ready running bit
//
// Arrivals, oversize errors, clears and empty reads load the result register directly;
// a read that returns an entry waits in S_READ for the registered ring memory data.
// One word is in flight at a time; a new word can be taken in the cycle the previous
// result is taken, so the output register parts the two sides.
// Reset is synchronous; it clears pointers, counters and running, not the ring.
// out_stall holds the result register and blocks new input words.

module sequenced_packet_ring_buffer #(
  parameter int RING_DEPTH = srb_pkg::DEFAULT_RING_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_kind,
  input  wire logic [srb_pkg::SEQ_W-1:0] in_sequence_number,
  input  wire logic                      in_hardware_overrun,
  input  wire logic                      in_length_matches,
  input  wire logic [srb_pkg::WORD_W-1:0] in_payload_word,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_entry_valid,
  output logic [srb_pkg::SLOT_W-1:0]     out_slot,
  output logic [srb_pkg::WORD_W-1:0]     out_payload_out,
  output logic                           out_overflow_seen,
  output logic                           out_gap_flag,
  output logic                           out_overwrite_flag,
  output logic [srb_pkg::HELD_W-1:0]     out_items_held,
  output logic [srb_pkg::CNT_W-1:0]      out_network_overrun_total,
  output logic [srb_pkg::CNT_W-1:0]      out_buffer_overrun_total,
  output logic [srb_pkg::SEQ_W-1:0]      out_last_gap,
  output logic [srb_pkg::CNT_W-1:0]      out_hardware_overflow_total,
  output logic [srb_pkg::CNT_W-1:0]      out_packets_read_total,

  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_running
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int SLW = (AW > srb_pkg::SLOT_W) ? AW : srb_pkg::SLOT_W;
  localparam int HLW = (CW > srb_pkg::HELD_W) ? CW : srb_pkg::HELD_W;

  srb_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]              oldest_r, oldest_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [srb_pkg::SEQ_W-1:0]  exp_r, exp_nxt;
  logic [srb_pkg::SEQ_W-1:0]  skip_r, skip_nxt;
  logic [srb_pkg::CNT_W-1:0]  net_r, net_nxt;
  logic [srb_pkg::CNT_W-1:0]  bufovr_r, bufovr_nxt;
  logic [srb_pkg::CNT_W-1:0]  hwovf_r, hwovf_nxt;
  logic [srb_pkg::CNT_W-1:0]  pkts_r, pkts_nxt;
  logic                       running_r;
  logic [AW-1:0]              pend_slot_r, pend_slot_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        ent_valid_r, ent_valid_nxt;
  logic [srb_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [srb_pkg::WORD_W-1:0]  pay_r, pay_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        gap_r, gap_nxt;
  logic                        ovw_r, ovw_nxt;

  logic                          accept;
  srb_pkg::kind_t                kind;
  logic                          mem_wr_en;
  logic [AW-1:0]                 mem_wr_addr;
  logic [srb_pkg::ENTRY_W-1:0]   mem_wr_data;
  logic                          mem_rd_en;
  logic [srb_pkg::ENTRY_W-1:0]   mem_rd_data;

  logic [CW:0]                   wr_sum;
  logic [CW:0]                   wr_sum_wrapped;
  logic [AW-1:0]                 wr_idx;
  logic [AW:0]                   oldest_plus;
  logic [AW-1:0]                 oldest_inc;
  logic                          seq_gap;
  logic                          ring_full;
  logic [CW-1:0]                 count_dec;
  logic [srb_pkg::FLAG_W-1:0]    arr_flags;
  logic [srb_pkg::FLAG_W-1:0]    rd_flags;
  logic [SLW-1:0]                wr_idx_wide;
  logic [SLW-1:0]                pend_wide;
  logic [HLW-1:0]                held_wide;

  // Only one word is worked on at a time, so a read never overlaps the write
  // of an earlier arrival to the same entry.
  assign accept    = in_valid && !in_stall;
  assign in_stall  = !((state_r == srb_pkg::S_IDLE) && (!out_valid_r || !out_stall));
  assign cfg_ready = 1'b1;
  assign kind      = srb_pkg::kind_t'(in_kind);

  // The sum stays below twice the depth, so one subtract brings it back in range.
  assign wr_sum         = (CW + 1)'(oldest_r) + (CW + 1)'(count_r);
  assign wr_sum_wrapped = (wr_sum >= (CW + 1)'(RING_DEPTH)) ?
                          (wr_sum - (CW + 1)'(RING_DEPTH)) : wr_sum;
  assign wr_idx         = wr_sum_wrapped[AW-1:0];

  assign oldest_plus = {1'b0, oldest_r} + (AW + 1)'(1);
  assign oldest_inc  = (oldest_plus == (AW + 1)'(RING_DEPTH)) ? '0 : oldest_plus[AW-1:0];

  assign seq_gap   = (in_sequence_number != exp_r);
  assign ring_full = (count_r == CW'(RING_DEPTH));
  assign count_dec = count_r - CW'(1);

  always_comb begin
    arr_flags = '0;
    arr_flags[srb_pkg::FLAG_HW]  = in_hardware_overrun;
    arr_flags[srb_pkg::FLAG_GAP] = seq_gap;
    arr_flags[srb_pkg::FLAG_OVW] = ring_full;
  end

  assign rd_flags    = mem_rd_data[srb_pkg::ENTRY_W-1 -: srb_pkg::FLAG_W];
  assign wr_idx_wide = SLW'(wr_idx);
  assign pend_wide   = SLW'(pend_slot_r);
  assign held_wide   = HLW'(count_r);

  assign mem_wr_addr = wr_idx;
  assign mem_wr_data = {arr_flags, in_payload_word};

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    exp_nxt       = exp_r;
    skip_nxt      = skip_r;
    net_nxt       = net_r;
    bufovr_nxt    = bufovr_r;
    hwovf_nxt     = hwovf_r;
    pkts_nxt      = pkts_r;
    pend_slot_nxt = pend_slot_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    ent_valid_nxt = ent_valid_r;
    slot_nxt      = slot_r;
    pay_nxt       = pay_r;
    ovf_nxt       = ovf_r;
    gap_nxt       = gap_r;
    ovw_nxt       = ovw_r;

    case (state_r)
      srb_pkg::S_IDLE: begin
        if (accept) begin
          // Default result: empty apart from the totals.
          out_valid_nxt = 1'b1;
          ent_valid_nxt = 1'b0;
          slot_nxt      = '0;
          pay_nxt       = '0;
          ovf_nxt       = 1'b0;
          gap_nxt       = 1'b0;
          ovw_nxt       = 1'b0;
          case (kind)
            srb_pkg::KIND_ARRIVAL: begin
              if (in_length_matches) begin
                mem_wr_en = 1'b1;
                // On a gap the expected count resyncs to the received number first.
                exp_nxt   = in_sequence_number + srb_pkg::SEQ_W'(1);
                if (seq_gap) begin
                  net_nxt  = net_r + srb_pkg::CNT_W'(1);
                  skip_nxt = in_sequence_number - exp_r;
                end
                if (ring_full) begin
                  oldest_nxt = oldest_inc;
                  bufovr_nxt = bufovr_r + srb_pkg::CNT_W'(1);
                end else begin
                  count_nxt = count_r + CW'(1);
                end
                slot_nxt = wr_idx_wide[srb_pkg::SLOT_W-1:0];
                gap_nxt  = seq_gap;
                ovw_nxt  = ring_full;
              end
            end
            srb_pkg::KIND_READ: begin
              if (running_r && (count_r != '0)) begin
                mem_rd_en     = 1'b1;
                pend_slot_nxt = oldest_r;
                count_nxt     = count_dec;
                pkts_nxt      = pkts_r + srb_pkg::CNT_W'(1);
                // A read that drains the ring leaves the oldest pointer in place.
                if (count_dec != '0) begin
                  oldest_nxt = oldest_inc;
                end
                out_valid_nxt = 1'b0;
                state_nxt     = srb_pkg::S_READ;
              end
            end
            srb_pkg::KIND_OVERSIZE: begin
              net_nxt = net_r + srb_pkg::CNT_W'(1);
            end
            srb_pkg::KIND_CLEAR: begin
              oldest_nxt = '0;
              count_nxt  = '0;
              exp_nxt    = '0;
              net_nxt    = '0;
              bufovr_nxt = '0;
              skip_nxt   = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      srb_pkg::S_READ: begin
        out_valid_nxt = 1'b1;
        ent_valid_nxt = 1'b1;
        slot_nxt      = pend_wide[srb_pkg::SLOT_W-1:0];
        pay_nxt       = mem_rd_data[srb_pkg::WORD_W-1:0];
        ovf_nxt       = rd_flags[srb_pkg::FLAG_HW];
        gap_nxt       = rd_flags[srb_pkg::FLAG_GAP];
        ovw_nxt       = rd_flags[srb_pkg::FLAG_OVW];
        if (rd_flags[srb_pkg::FLAG_HW]) begin
          hwovf_nxt = hwovf_r + srb_pkg::CNT_W'(1);
        end
        state_nxt = srb_pkg::S_IDLE;
      end
      default: begin
        state_nxt = srb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srb_pkg::S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      exp_r       <= '0;
      skip_r      <= '0;
      net_r       <= '0;
      bufovr_r    <= '0;
      hwovf_r     <= '0;
      pkts_r      <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      exp_r       <= exp_nxt;
      skip_r      <= skip_nxt;
      net_r       <= net_nxt;
      bufovr_r    <= bufovr_nxt;
      hwovf_r     <= hwovf_nxt;
      pkts_r      <= pkts_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        running_r <= cfg_running;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    ent_valid_r <= ent_valid_nxt;
    slot_r      <= slot_nxt;
    pay_r       <= pay_nxt;
    ovf_r       <= ovf_nxt;
    gap_r       <= gap_nxt;
    ovw_r       <= ovw_nxt;
  end

  srb_ring_mem #(
    .DEPTH (RING_DEPTH),
    .DW    (srb_pkg::ENTRY_W)
  ) u_ring_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (oldest_r),
    .rd_data_r (mem_rd_data)
  );

  // The totals come straight from the state: it only moves when a new word is
  // taken, which cannot happen while a result waits under stall.
  assign out_valid                   = out_valid_r;
  assign out_entry_valid             = ent_valid_r;
  assign out_slot                    = slot_r;
  assign out_payload_out             = pay_r;
  assign out_overflow_seen           = ovf_r;
  assign out_gap_flag                = gap_r;
  assign out_overwrite_flag          = ovw_r;
  assign out_items_held              = held_wide[srb_pkg::HELD_W-1:0];
  assign out_network_overrun_total   = net_r;
  assign out_buffer_overrun_total    = bufovr_r;
  assign out_last_gap                = skip_r;
  assign out_hardware_overflow_total = hwovf_r;
  assign out_packets_read_total      = pkts_r;

endmodule

`default_nettype wire

[rtl/srb_ring_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module srb_ring_mem #(
  parameter int DEPTH = srb_pkg::DEFAULT_RING_DEPTH,
  parameter int DW    = srb_pkg::ENTRY_W
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[verif/tb_sequenced_packet_ring_buffer.sv]
`timescale 1ns / 1ps

module tb_sequenced_packet_ring_buffer;

  localparam int RING_DEPTH     = srb_pkg::DEFAULT_RING_DEPTH;
  localparam int SEQ_W          = srb_pkg::SEQ_W;
  localparam int WORD_W         = srb_pkg::WORD_W;
  localparam int CNT_W          = srb_pkg::CNT_W;
  localparam int SLOT_W         = srb_pkg::SLOT_W;
  localparam int HELD_W         = srb_pkg::HELD_W;
  localparam int FLAG_W         = srb_pkg::FLAG_W;
  localparam int FLAG_HW        = srb_pkg::FLAG_HW;
  localparam int FLAG_GAP       = srb_pkg::FLAG_GAP;
  localparam int FLAG_OVW       = srb_pkg::FLAG_OVW;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic              entry_valid;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] payload;
    logic              overflow_seen;
    logic              gap_flag;
    logic              overwrite_flag;
    logic [HELD_W-1:0] items_held;
    logic [CNT_W-1:0]  network_total;
    logic [CNT_W-1:0]  buffer_total;
    logic [SEQ_W-1:0]  last_gap;
    logic [CNT_W-1:0]  hw_overflow_total;
    logic [CNT_W-1:0]  packets_read_total;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  srb_pkg::kind_t    in_kind = srb_pkg::KIND_ARRIVAL;
  logic [SEQ_W-1:0]  in_sequence_number = '0;
  logic              in_hardware_overrun = 1'b0;
  logic              in_length_matches = 1'b0;
  logic [WORD_W-1:0] in_payload_word = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_entry_valid;
  logic [SLOT_W-1:0] out_slot;
  logic [WORD_W-1:0] out_payload_out;
  logic              out_overflow_seen;
  logic              out_gap_flag;
  logic              out_overwrite_flag;
  logic [HELD_W-1:0] out_items_held;
  logic [CNT_W-1:0]  out_network_overrun_total;
  logic [CNT_W-1:0]  out_buffer_overrun_total;
  logic [SEQ_W-1:0]  out_last_gap;
  logic [CNT_W-1:0]  out_hardware_overflow_total;
  logic [CNT_W-1:0]  out_packets_read_total;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_running = 1'b0;

  // Predictor state: the ring contents, pointers, counters and the running bit.
  logic [WORD_W-1:0] ring_words [RING_DEPTH];
  logic [FLAG_W-1:0] ring_marks [RING_DEPTH];
  int unsigned       head_slot = 0;
  int unsigned       held_count = 0;
  logic [SEQ_W-1:0]  next_seq = '0;
  logic [CNT_W-1:0]  net_overruns = '0;
  logic [CNT_W-1:0]  buf_overruns = '0;
  logic [SEQ_W-1:0]  last_skip = '0;
  logic [CNT_W-1:0]  hw_overflows = '0;
  logic [CNT_W-1:0]  reads_done = '0;
  logic              stream_on = 1'b0;

  ring_result_t      pending_results [$];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  // Stimulus side: sequence number the sender treats as in order.
  logic [SEQ_W-1:0]  stim_seq = '0;

  bit                idle_on = 1'b0;
  bit                hold_ask = 1'b0;
  bit                hold_taken = 1'b0;
  int                stall_left = 0;

  sequenced_packet_ring_buffer dut (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .in_valid                    (in_valid),
    .in_stall                    (in_stall),
    .in_kind                     (in_kind),
    .in_sequence_number          (in_sequence_number),
    .in_hardware_overrun         (in_hardware_overrun),
    .in_length_matches           (in_length_matches),
    .in_payload_word             (in_payload_word),
    .out_valid                   (out_valid),
    .out_stall                   (out_stall),
    .out_entry_valid             (out_entry_valid),
    .out_slot                    (out_slot),
    .out_payload_out             (out_payload_out),
    .out_overflow_seen           (out_overflow_seen),
    .out_gap_flag                (out_gap_flag),
    .out_overwrite_flag          (out_overwrite_flag),
    .out_items_held              (out_items_held),
    .out_network_overrun_total   (out_network_overrun_total),
    .out_buffer_overrun_total    (out_buffer_overrun_total),
    .out_last_gap                (out_last_gap),
    .out_hardware_overflow_total (out_hardware_overflow_total),
    .out_packets_read_total      (out_packets_read_total),
    .cfg_valid                   (cfg_valid),
    .cfg_ready                   (cfg_ready),
    .cfg_running                 (cfg_running)
  );

  always #4 clk = ~clk;

  function automatic ring_result_t predict_result(srb_pkg::kind_t kind,
      logic [SEQ_W-1:0] seq, logic hw, logic len_ok, logic [WORD_W-1:0] word);
    ring_result_t r;
    logic [FLAG_W-1:0] marks;
    int unsigned idx;
    r = '{default: '0};
    case (kind)
      srb_pkg::KIND_ARRIVAL: begin
        if (len_ok) begin
          marks = '0;
          marks[FLAG_HW] = hw;
          idx = (head_slot + held_count) % RING_DEPTH;
          if (seq != next_seq) begin
            marks[FLAG_GAP] = 1'b1;
            net_overruns += 1'b1;
            last_skip = seq - next_seq;
            next_seq = seq;
          end
          if (held_count < RING_DEPTH) begin
            held_count++;
          end else begin
            // Full ring: the oldest entry is lost to the new one.
            head_slot = (head_slot + 1) % RING_DEPTH;
            marks[FLAG_OVW] = 1'b1;
            buf_overruns += 1'b1;
          end
          ring_words[idx] = word;
          ring_marks[idx] = marks;
          next_seq += 1'b1;
          r.slot = idx[SLOT_W-1:0];
          r.gap_flag = marks[FLAG_GAP];
          r.overwrite_flag = marks[FLAG_OVW];
        end
      end
      srb_pkg::KIND_READ: begin
        if (stream_on && held_count > 0) begin
          idx = head_slot;
          marks = ring_marks[idx];
          r.entry_valid = 1'b1;
          r.slot = idx[SLOT_W-1:0];
          r.payload = ring_words[idx];
          reads_done += 1'b1;
          if (marks[FLAG_HW]) begin
            hw_overflows += 1'b1;
            r.overflow_seen = 1'b1;
          end
          r.gap_flag = marks[FLAG_GAP];
          r.overwrite_flag = marks[FLAG_OVW];
          held_count--;
          // Draining the ring leaves the head where it was.
          if (held_count > 0) head_slot = (idx + 1) % RING_DEPTH;
        end
      end
      srb_pkg::KIND_OVERSIZE: begin
        net_overruns += 1'b1;
      end
      default: begin
        head_slot = 0;
        held_count = 0;
        next_seq = '0;
        net_overruns = '0;
        buf_overruns = '0;
        last_skip = '0;
      end
    endcase
    r.items_held = held_count[HELD_W-1:0];
    r.network_total = net_overruns;
    r.buffer_total = buf_overruns;
    r.last_gap = last_skip;
    r.hw_overflow_total = hw_overflows;
    r.packets_read_total = reads_done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  // Prediction runs before the comparison so that ordering within one edge is moot.
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) stream_on = cfg_running;
      if (in_valid && !in_stall)
        pending_results.insert(pending_results.size(), predict_result(in_kind,
            in_sequence_number, in_hardware_overrun, in_length_matches, in_payload_word));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result word with no expectation pending", $realtime);
        end else begin
          want = pending_results.pop_front();
          check_field("entry_valid", 32'(want.entry_valid), 32'(out_entry_valid));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("payload_out", want.payload, out_payload_out);
          check_field("overflow_seen", 32'(want.overflow_seen), 32'(out_overflow_seen));
          check_field("gap_flag", 32'(want.gap_flag), 32'(out_gap_flag));
          check_field("overwrite_flag", 32'(want.overwrite_flag), 32'(out_overwrite_flag));
          check_field("items_held", 32'(want.items_held), 32'(out_items_held));
          check_field("network_overrun_total", want.network_total,
              out_network_overrun_total);
          check_field("buffer_overrun_total", want.buffer_total, out_buffer_overrun_total);
          check_field("last_gap", 32'(want.last_gap), 32'(out_last_gap));
          check_field("hardware_overflow_total", want.hw_overflow_total,
              out_hardware_overflow_total);
          check_field("packets_read_total", want.packets_read_total,
              out_packets_read_total);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_ask != hold_taken) begin
      hold_taken <= hold_ask;
      stall_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_sequenced_packet_ring_buffer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(srb_pkg::kind_t kind, logic [SEQ_W-1:0] seq, logic hw,
      logic len_ok, logic [WORD_W-1:0] word);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sequence_number <= seq;
    in_hardware_overrun <= hw;
    in_length_matches <= len_ok;
    in_payload_word <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_packet(bit in_order);
    logic [SEQ_W-1:0] seq;
    if (in_order) begin
      seq = stim_seq;
    end else begin
      case ($urandom_range(0, 3))
        0: seq = '0;
        1: seq = '1;
        2: seq = stim_seq - 1'b1;
        default: seq = SEQ_W'($urandom);
      endcase
    end
    send_word(srb_pkg::KIND_ARRIVAL, seq, 1'($urandom_range(0, 1)), 1'b1, $urandom);
    stim_seq = seq + 1'b1;
  endtask

  // Reads, oversize errors, clears and short arrivals carry random unused fields.
  task automatic send_other(srb_pkg::kind_t kind);
    send_word(kind, SEQ_W'($urandom), 1'($urandom_range(0, 1)),
        kind != srb_pkg::KIND_ARRIVAL && ($urandom_range(0, 1) != 0), $urandom);
    if (kind == srb_pkg::KIND_CLEAR) stim_seq = '0;
  endtask

  task automatic send_random_items(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) send_packet($urandom_range(0, 99) < 88);
      else if (pick < 85) send_other(srb_pkg::KIND_READ);
      else if (pick < 90) send_other(srb_pkg::KIND_OVERSIZE);
      else if (pick < 96) send_other(srb_pkg::KIND_ARRIVAL);
      else send_other(srb_pkg::KIND_CLEAR);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_running(logic value);
    cfg_valid <= 1'b1;
    cfg_running <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stream stopped: arrivals are taken, reads come back empty.
  task automatic test_idle_before_start();
    write_running(1'b0);
    send_other(srb_pkg::KIND_READ);
    send_word(srb_pkg::KIND_ARRIVAL, 16'h0000, 1'b0, 1'b1, 32'h0000_0000);
    send_other(srb_pkg::KIND_READ);
    send_other(srb_pkg::KIND_OVERSIZE);
    send_word(srb_pkg::KIND_ARRIVAL, 16'h1234, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_other(srb_pkg::KIND_CLEAR);
    wait_for_results();
    write_running(1'b1);
  endtask

  task automatic test_directed_cases();
    send_other(srb_pkg::KIND_READ);
    send_word(srb_pkg::KIND_ARRIVAL, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_word(srb_pkg::KIND_ARRIVAL, 16'hFFFF, 1'b0, 1'b1, 32'h0000_0000);
    send_word(srb_pkg::KIND_ARRIVAL, 16'h0000, 1'b0, 1'b1, 32'hA5A5_5A5A);
    repeat (3) send_other(srb_pkg::KIND_READ);
    // The ring is empty again; the next word lands on the slot just read.
    send_word(srb_pkg::KIND_ARRIVAL, 16'h0001, 1'b1, 1'b1, 32'h8000_0001);
    send_word(srb_pkg::KIND_ARRIVAL, 16'h0005, 1'b0, 1'b1, 32'h7FFF_FFFE);
    repeat (2) send_other(srb_pkg::KIND_READ);
    send_other(srb_pkg::KIND_OVERSIZE);
    send_other(srb_pkg::KIND_CLEAR);
    send_word(srb_pkg::KIND_ARRIVAL, 16'h0000, 1'b0, 1'b1, 32'h1234_5678);
    send_other(srb_pkg::KIND_READ);
    stim_seq = 16'h0001;
  endtask

  // Fill past the ring size so the oldest entries get overwritten, starting
  // under a long receiver hold-off that backs up the input.
  task automatic test_ring_wraparound();
    idle_on <= 1'b1;
    hold_ask <= ~hold_ask;
    repeat (280) begin
      if ($urandom_range(0, 19) == 0) send_other(srb_pkg::KIND_ARRIVAL);
      send_packet($urandom_range(0, 19) != 0);
    end
    repeat (60) send_other(srb_pkg::KIND_READ);
  endtask

  task automatic test_mixed_traffic();
    send_random_items(150);
  endtask

  task automatic test_stream_stop();
    wait_for_results();
    write_running(1'b0);
    send_random_items(60);
    wait_for_results();
    write_running(1'b1);
    send_random_items(120);
  endtask

  task automatic test_full_rate();
    idle_on <= 1'b0;
    send_random_items(100);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_before_start();
    test_directed_cases();
    test_ring_wraparound();
    test_mixed_traffic();
    test_stream_stop();
    test_full_rate();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("tb_sequenced_packet_ring_buffer: done, clean");
    else
      $display("tb_sequenced_packet_ring_buffer: done, errors");
    $finish;
  end

endmodule

[sim.f]
rtl/srb_pkg.sv
rtl/srb_ring_mem.sv
rtl/sequenced_packet_ring_buffer.sv
verif/tb_sequenced_packet_ring_buffer.sv
